FILE: sv/wps_pkg.sv
// Package for the wildcard pattern search block.
// Holds the beat types, configuration register indexes and shared constants.
// No dependencies.
package wps_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 16;
    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned REG_BYTES = 16;
    localparam int unsigned LEN_W = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned RESULT_OFFSET_W = 32;
    localparam logic [7:0] WILDCARD = 8'h2A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } in_beat_t;

    typedef struct packed {
        logic                       found;
        logic [RESULT_OFFSET_W-1:0] match_offset;
    } out_beat_t;

endpackage

FILE: sv/wps_match.sv
// Window compare for the wildcard pattern search block.
// Compares the most recent bytes against the configured pattern; uses wps_pkg.
module wps_match #(
    parameter int unsigned WIN = wps_pkg::MAX_PATTERN_DEF
) (
    input  logic [WIN-1:0][7:0]                       window,
    input  logic [wps_pkg::REG_BYTES-1:0][7:0]        pattern,
    input  logic [wps_pkg::LEN_W-1:0]                 length,
    output logic                                      match
);

    logic [WIN-1:0] byte_ok;

    always_comb
    begin
        logic [wps_pkg::LEN_W-1:0] pat_pos;
        logic [7:0]                pat_byte;
        for (int k = 0; k < WIN; k++)
        begin
            pat_pos  = length - wps_pkg::LEN_W'(k) - wps_pkg::LEN_W'(1);
            pat_byte = pattern[pat_pos[3:0]];
            byte_ok[k] = (wps_pkg::LEN_W'(k) >= length)
                      || (pat_byte == wps_pkg::WILDCARD)
                      || (pat_byte == window[k]);
        end
        match = &byte_ok;
    end

endmodule

FILE: sv/wildcard_pattern_search_top.sv
// Wildcard pattern search: input beats are held in s1_data_reg and results in out_data_reg.
// Throughput is one byte per cycle; the input register and result register stall only while
// a result beat waits on out_ready. The window compare is combinational and fully parallel.
// Reset clears the region state, the pipeline valid flags and the pattern registers
// (pattern length resets to 1). Uses wps_pkg and wps_match.
module wildcard_pattern_search_top #(
    parameter int unsigned MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
    parameter int unsigned OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wps_pkg::in_beat_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output wps_pkg::out_beat_t                  out_data,
    input  logic                                cfg_we,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int unsigned WIN = (MAX_PATTERN < wps_pkg::REG_BYTES) ?
                                  MAX_PATTERN : wps_pkg::REG_BYTES;
    localparam logic [wps_pkg::LEN_W-1:0] LIMIT_LEN = wps_pkg::LEN_W'(WIN);
    localparam logic [OFFSET_BITS-1:0] INDEX_MAX = '1;

    logic [wps_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [wps_pkg::CFG_DATA_W-1:0] pattern_high_reg;
    logic [wps_pkg::LEN_W-1:0]      pattern_length_reg;

    logic                           s1_valid_reg;
    wps_pkg::in_beat_t              s1_data_reg;

    logic [WIN-1:0][7:0]            window_reg;
    logic [WIN-1:0][7:0]            window_next;
    logic [OFFSET_BITS-1:0]         index_reg;
    logic [OFFSET_BITS-1:0]         index_next;
    logic                           match_done_reg;
    logic                           match_done_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    wps_pkg::out_beat_t             out_data_reg;
    wps_pkg::out_beat_t             out_data_next;

    logic                           advance;
    logic [wps_pkg::LEN_W-1:0]      length_eff;
    logic [OFFSET_BITS-1:0]         index_inc;
    logic [OFFSET_BITS-1:0]         offset_diff;
    logic                           window_hit;
    logic                           hit;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= wps_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                wps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                wps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[wps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            length_eff = wps_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > LIMIT_LEN)
        begin
            length_eff = LIMIT_LEN;
        end
        else
        begin
            length_eff = pattern_length_reg;
        end
    end

    always_comb
    begin
        window_next[0] = s1_data_reg.data_byte;
        for (int k = 1; k < WIN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    assign index_inc   = (index_reg == INDEX_MAX) ? index_reg : index_reg + OFFSET_BITS'(1);
    assign offset_diff = index_inc - OFFSET_BITS'(length_eff);

    wps_match #(
        .WIN (WIN)
    ) u_match (
        .window  (window_next),
        .pattern ({pattern_high_reg, pattern_low_reg}),
        .length  (length_eff),
        .match   (window_hit)
    );

    assign hit = !match_done_reg && window_hit && (index_inc >= OFFSET_BITS'(length_eff));

    always_comb
    begin
        index_next      = index_reg;
        match_done_next = match_done_reg;
        out_valid_next  = 1'b0;
        out_data_next   = '0;
        if (!match_done_reg)
        begin
            index_next = index_inc;
        end
        if (hit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.found        = 1'b1;
            out_data_next.match_offset = wps_pkg::RESULT_OFFSET_W'(offset_diff);
            match_done_next            = 1'b1;
        end
        else if (!match_done_reg && s1_data_reg.region_end)
        begin
            out_valid_next = 1'b1;
        end
        if (s1_data_reg.region_end)
        begin
            index_next      = '0;
            match_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            window_reg     <= '0;
            index_reg      <= '0;
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && out_valid_next;
                if (s1_valid_reg)
                begin
                    index_reg      <= index_next;
                    match_done_reg <= match_done_next;
                    if (!match_done_reg)
                    begin
                        window_reg <= window_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (advance && s1_valid_reg && out_valid_next)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_done_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        match_done_reg |-> (index_reg != '0))
        else $error("match flag set with an empty byte count");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.match_offset == '0))
        else $error("not-found result carries a nonzero offset");

    a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && hit && !s1_data_reg.region_end) |=> match_done_reg)
        else $error("match did not mark the region as done");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a waiting result beat");

endmodule
